@@ design/cpcr_pkg.sv @@
package cpcr_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_RADIUS      = 1'b0,
        REG_RESTITUTION = 1'b1
    } t_reg_idx;

    localparam int CFG_W    = 30;
    localparam int RADIUS_W = 30;
    localparam int REST_W   = 18;
    localparam int HEAT_W   = 31;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 30'd65536;
    localparam logic [REST_W-1:0]   REST_RST   = 18'd32768;

    // Integer square root: 63-bit radicand, 32-bit root, one result bit per stage
    localparam int SQRT_IN_W  = 63;
    localparam int SQRT_OUT_W = 32;
    localparam int SQRT_STEPS = 32;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [HEAT_W-1:0] HEAT_MAX = 31'h7FFF_FFFF;

endpackage

@@ design/cpcr_delay.sv @@
module cpcr_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_sh [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_d = r_sh[D-1];

endmodule

@@ design/cpcr_isqrt.sv @@
module cpcr_isqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [cpcr_pkg::SQRT_IN_W-1:0]  i_val,
    output logic [cpcr_pkg::SQRT_OUT_W-1:0] o_root
);
    import cpcr_pkg::*;

    localparam int AW = SQRT_IN_W + 1;

    logic [AW-1:0] w_v   [0:SQRT_STEPS-1];
    logic [AW-1:0] w_res [0:SQRT_STEPS];

    assign w_v[0]   = AW'(i_val);
    assign w_res[0] = '0;

    // One digit-pair of the classic shift-and-subtract root per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [AW-1:0] BIT = AW'(1) << (SQRT_IN_W - 1 - 2 * k);
        logic [AW-1:0] w_trial;
        logic          w_ge;
        logic [AW-1:0] n_res;
        logic [AW-1:0] r_res;

        assign w_trial = w_res[k] + BIT;
        assign w_ge    = (w_v[k] >= w_trial);
        assign n_res   = w_ge ? ((w_res[k] >> 1) + BIT) : (w_res[k] >> 1);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res <= n_res;
            end
        end
        assign w_res[k+1] = r_res;

        if (k < SQRT_STEPS - 1) begin : g_rem
            logic [AW-1:0] n_v;
            logic [AW-1:0] r_v;
            assign n_v = w_ge ? (w_v[k] - w_trial) : w_v[k];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v <= n_v;
                end
            end
            assign w_v[k+1] = r_v;
        end
    end

    assign o_root = w_res[SQRT_STEPS][SQRT_OUT_W-1:0];

endmodule

@@ design/cpcr_frac_div.sv @@
module cpcr_frac_div #(
    parameter int W  = 32,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    output logic [QW-1:0] o_quo
);
    // Quotient floor(num * 2^(QW-1) / den) for num <= den, one bit per stage
    logic [W-1:0]  w_rem [0:QW-1];
    logic [W-1:0]  w_den [0:QW-1];
    logic [QW-1:0] w_quo [0:QW];

    assign w_rem[0] = i_num;
    assign w_den[0] = i_den;
    assign w_quo[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [W:0]    w_trial;
        logic          w_ge;
        logic [QW-1:0] n_quo;
        logic [QW-1:0] r_quo;

        if (k == 0) begin : g_first
            assign w_trial = {1'b0, w_rem[k]};
        end else begin : g_next
            assign w_trial = {w_rem[k], 1'b0};
        end

        assign w_ge  = (w_trial >= {1'b0, w_den[k]});
        assign n_quo = {w_quo[k][QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo <= n_quo;
            end
        end
        assign w_quo[k+1] = r_quo;

        if (k < QW - 1) begin : g_rem
            logic [W:0]   w_diff;
            logic [W-1:0] n_rem;
            logic [W-1:0] r_rem;
            logic [W-1:0] r_den;
            assign w_diff = w_trial - {1'b0, w_den[k]};
            assign n_rem  = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_rem;
                    r_den <= w_den[k];
                end
            end
            assign w_rem[k+1] = r_rem;
            assign w_den[k+1] = r_den;
        end
    end

    assign o_quo = w_quo[QW];

endmodule

@@ design/circle_pair_collision_response_unit.sv @@
// Throughput: one pair word per cycle; the whole pipeline advances together, so it
// stalls only while the output register holds a word that the sink has not taken.
// The 32-stage square root and the (FRAC_BITS+1)-stage dividers set the depth.
// Reset (i_rst_n low, synchronous) clears all valid bits and loads radius 1.0 and
// restitution 0.5; payload registers are not reset.
module circle_pair_collision_response_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input pair channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_pos_a_x,
    input  logic signed [31:0]            i_pos_a_y,
    input  logic signed [31:0]            i_pos_b_x,
    input  logic signed [31:0]            i_pos_b_y,
    input  logic signed [31:0]            i_vel_a_x,
    input  logic signed [31:0]            i_vel_a_y,
    input  logic signed [31:0]            i_vel_b_x,
    input  logic signed [31:0]            i_vel_b_y,
    input  logic [cpcr_pkg::HEAT_W-1:0]   i_heat_a,
    input  logic [cpcr_pkg::HEAT_W-1:0]   i_heat_b,
    input  logic [30:0]                   i_separation,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_contact,
    output logic signed [31:0]            o_push_x,
    output logic signed [31:0]            o_push_y,
    output logic signed [31:0]            o_vel_delta_x,
    output logic signed [31:0]            o_vel_delta_y,
    output logic [cpcr_pkg::HEAT_W-1:0]   o_heat_new,
    // configuration write port
    input  logic                          i_cfg_we,
    input  cpcr_pkg::t_reg_idx            i_cfg_idx,
    input  logic [cpcr_pkg::CFG_W-1:0]    i_cfg_data
);
    import cpcr_pkg::*;

    localparam int QW   = FRAC_BITS + 1;              // unit normal / weight width
    localparam int PW   = QW + 34;                    // rv * n product
    localparam int RW   = ((FRAC_BITS > REST_W) ? FRAC_BITS : REST_W) + 1;
    localparam int SW   = 32 + RW - FRAC_BITS - 1;    // |s| width
    localparam int MW   = SW + 1;                     // |s * n| >> F width
    localparam int NST  = 42 + QW;                    // register stages end to end
    localparam int DL_A = 35 + QW;
    localparam int DL_B = 34 + QW;

    localparam logic signed [PW:0] TRUNC_BIAS = (PW+1)'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [PW:0] SUM_MAX    = (PW+1)'(32'sh7FFF_FFFF);
    localparam logic signed [PW:0] SUM_MIN    = (PW+1)'(32'sh8000_0000);
    localparam logic [RW-1:0]      ONE_Q      = RW'(64'd1 << FRAC_BITS);
    localparam logic [MW-1:0]      POS_LIM    = MW'(64'h7FFF_FFFF);
    localparam logic [MW-1:0]      NEG_LIM    = MW'(64'h8000_0000);

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    logic [RADIUS_W-1:0] r_radius;
    logic [REST_W-1:0]   r_restitution;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RADIUS_RST;
            r_restitution <= REST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS:      r_radius      <= i_cfg_data[RADIUS_W-1:0];
                REG_RESTITUTION: r_restitution <= i_cfg_data[REST_W-1:0];
                default:         r_radius      <= r_radius;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control: every stage moves when the output word is free or taken
    // ---------------------------------------------------------------------
    logic           w_en;
    logic [NST-1:0] r_v;

    assign w_en    = ~r_v[NST-1] | i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: differences, overlap, contact test, weight operands
    // ---------------------------------------------------------------------
    logic signed [32:0] n1_dx, n1_dy, n1_rvx, n1_rvy;
    logic [30:0]        n1_two_r;
    logic [32:0]        n1_hnum, n1_hsum;

    assign n1_dx    = 33'(i_pos_a_x) - 33'(i_pos_b_x);
    assign n1_dy    = 33'(i_pos_a_y) - 33'(i_pos_b_y);
    assign n1_rvx   = 33'(i_vel_a_x) - 33'(i_vel_b_x);
    assign n1_rvy   = 33'(i_vel_a_y) - 33'(i_vel_b_y);
    assign n1_two_r = {r_radius, 1'b0};
    assign n1_hnum  = 33'(i_heat_b) + 33'(ONE_Q);
    assign n1_hsum  = 33'(i_heat_a) + 33'(i_heat_b) + (33'(ONE_Q) << 1);

    logic signed [32:0] r1_dx, r1_dy, r1_rvx, r1_rvy;
    logic [30:0]        r1_ovl;
    logic               r1_contact;
    logic [32:0]        r1_hnum, r1_hsum;
    logic [HEAT_W-1:0]  r1_ha;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx      <= n1_dx;
            r1_dy      <= n1_dy;
            r1_rvx     <= n1_rvx;
            r1_rvy     <= n1_rvy;
            r1_ovl     <= n1_two_r - i_separation;
            r1_contact <= (i_separation <= n1_two_r);
            r1_hnum    <= n1_hnum;
            r1_hsum    <= n1_hsum;
            r1_ha      <= i_heat_a;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: magnitudes, scaled down until both fit in 31 bits
    // ---------------------------------------------------------------------
    logic [32:0] n2_ax, n2_ay;
    logic [30:0] n2_mx, n2_my;

    assign n2_ax = r1_dx[32] ? 33'(-r1_dx) : 33'(r1_dx);
    assign n2_ay = r1_dy[32] ? 33'(-r1_dy) : 33'(r1_dy);

    always_comb begin
        priority if (n2_ax[32] | n2_ay[32]) begin
            n2_mx = n2_ax[32:2];
            n2_my = n2_ay[32:2];
        end else if (n2_ax[31] | n2_ay[31]) begin
            n2_mx = n2_ax[31:1];
            n2_my = n2_ay[31:1];
        end else begin
            n2_mx = n2_ax[30:0];
            n2_my = n2_ay[30:0];
        end
    end

    logic [30:0] r2_mx, r2_my;
    logic        r2_sx, r2_sy, r2_zlen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mx   <= n2_mx;
            r2_my   <= n2_my;
            r2_sx   <= r1_dx[32];
            r2_sy   <= r1_dy[32];
            r2_zlen <= (n2_ax == '0) && (n2_ay == '0);
        end
    end

    // Stages 3 and 4: squares, then their sum
    logic [61:0]          r3_sqx, r3_sqy;
    logic [SQRT_IN_W-1:0] r4_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sqx <= 62'(r2_mx) * 62'(r2_mx);
            r3_sqy <= 62'(r2_my) * 62'(r2_my);
            r4_sum <= SQRT_IN_W'(r3_sqx) + SQRT_IN_W'(r3_sqy);
        end
    end

    // ---------------------------------------------------------------------
    // Length, then normal and heat weight dividers
    // ---------------------------------------------------------------------
    logic [SQRT_OUT_W-1:0] w_len;

    cpcr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r4_sum),
        .o_root (w_len)
    );

    logic [61:0] w_mxy_d;
    logic [65:0] w_hw_d;

    cpcr_delay #(.W(62), .D(SQRT_STEPS + 2)) u_dly_mag (
        .i_clk (i_clk), .i_en (w_en), .i_d ({r2_mx, r2_my}), .o_d (w_mxy_d)
    );
    cpcr_delay #(.W(66), .D(SQRT_STEPS + 3)) u_dly_heat (
        .i_clk (i_clk), .i_en (w_en), .i_d ({r1_hnum, r1_hsum}), .o_d (w_hw_d)
    );

    logic [QW-1:0] w_nmx, w_nmy, w_w;

    cpcr_frac_div #(.W(32), .QW(QW)) u_div_nx (
        .i_clk (i_clk), .i_en (w_en),
        .i_num ({1'b0, w_mxy_d[61:31]}), .i_den (w_len), .o_quo (w_nmx)
    );
    cpcr_frac_div #(.W(32), .QW(QW)) u_div_ny (
        .i_clk (i_clk), .i_en (w_en),
        .i_num ({1'b0, w_mxy_d[30:0]}), .i_den (w_len), .o_quo (w_nmy)
    );
    cpcr_frac_div #(.W(33), .QW(QW)) u_div_w (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (w_hw_d[65:33]), .i_den (w_hw_d[32:0]), .o_quo (w_w)
    );

    // Side data travels alongside the root and divider stages
    logic [128:0]       w_a_d;
    logic [2:0]         w_b_d;
    logic               a_contact;
    logic signed [32:0] a_rvx, a_rvy;
    logic [30:0]        a_ovl;
    logic [HEAT_W-1:0]  a_ha;
    logic               b_sx, b_sy, b_zlen;

    cpcr_delay #(.W(129), .D(DL_A)) u_dly_a (
        .i_clk (i_clk), .i_en (w_en),
        .i_d   ({r1_contact, r1_rvx, r1_rvy, r1_ovl, r1_ha}), .o_d (w_a_d)
    );
    cpcr_delay #(.W(3), .D(DL_B)) u_dly_b (
        .i_clk (i_clk), .i_en (w_en), .i_d ({r2_sx, r2_sy, r2_zlen}), .o_d (w_b_d)
    );

    assign {a_contact, a_rvx, a_rvy, a_ovl, a_ha} = w_a_d;
    assign {b_sx, b_sy, b_zlen}                   = w_b_d;

    // ---------------------------------------------------------------------
    // Stage 5: weighted overlap, relative velocity along the normal
    // ---------------------------------------------------------------------
    logic signed [QW:0]  n5_nxs, n5_nys;
    logic [30+QW:0]      n5_ovlw;

    assign n5_nxs  = b_sx ? -$signed({1'b0, w_nmx}) : $signed({1'b0, w_nmx});
    assign n5_nys  = b_sy ? -$signed({1'b0, w_nmy}) : $signed({1'b0, w_nmy});
    assign n5_ovlw = (31+QW)'(a_ovl) * (31+QW)'(w_w);

    logic [30:0]          r5_mag;
    logic signed [PW-1:0] r5_prx, r5_pry;
    logic [QW-1:0]        r5_nmx, r5_nmy;
    logic                 r5_sx, r5_sy, r5_zlen, r5_contact;
    logic [HEAT_W-1:0]    r5_ha;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_mag     <= n5_ovlw[30+FRAC_BITS:FRAC_BITS];
            r5_prx     <= PW'(a_rvx) * PW'(n5_nxs);
            r5_pry     <= PW'(a_rvy) * PW'(n5_nys);
            r5_nmx     <= w_nmx;
            r5_nmy     <= w_nmy;
            r5_sx      <= b_sx;
            r5_sy      <= b_sy;
            r5_zlen    <= b_zlen;
            r5_contact <= a_contact;
            r5_ha      <= a_ha;
        end
    end

    // Stage 6: push magnitudes, impact sum
    logic [30+QW:0] n6_pmx, n6_pmy;

    assign n6_pmx = (31+QW)'(r5_nmx) * (31+QW)'(r5_mag);
    assign n6_pmy = (31+QW)'(r5_nmy) * (31+QW)'(r5_mag);

    logic [30:0]        r6_pmx, r6_pmy;
    logic signed [PW:0] r6_sum;
    logic [QW-1:0]      r6_nmx, r6_nmy;
    logic               r6_sx, r6_sy, r6_zlen, r6_contact;
    logic [HEAT_W-1:0]  r6_ha;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_pmx     <= n6_pmx[30+FRAC_BITS:FRAC_BITS];
            r6_pmy     <= n6_pmy[30+FRAC_BITS:FRAC_BITS];
            r6_sum     <= (PW+1)'(r5_prx) + (PW+1)'(r5_pry);
            r6_nmx     <= r5_nmx;
            r6_nmy     <= r5_nmy;
            r6_sx      <= r5_sx;
            r6_sy      <= r5_sy;
            r6_zlen    <= r5_zlen;
            r6_contact <= r5_contact;
            r6_ha      <= r5_ha;
        end
    end

    // Stage 7: signed push, impact truncated toward zero and saturated
    logic signed [PW:0] n7_t;
    logic [31:0]        n7_imag;
    logic               n7_ile0;

    assign n7_t = (r6_sum < 0) ? ((r6_sum + TRUNC_BIAS) >>> FRAC_BITS)
                               : (r6_sum >>> FRAC_BITS);

    always_comb begin
        priority if (n7_t > SUM_MAX) begin
            n7_imag = 32'h7FFF_FFFF;
            n7_ile0 = 1'b0;
        end else if (n7_t < SUM_MIN) begin
            n7_imag = 32'h8000_0000;
            n7_ile0 = 1'b1;
        end else if (n7_t < 0) begin
            n7_imag = 32'(-n7_t);
            n7_ile0 = 1'b1;
        end else begin
            n7_imag = 32'(n7_t);
            n7_ile0 = (n7_t == 0);
        end
    end

    logic signed [31:0] r7_px, r7_py;
    logic [31:0]        r7_imag;
    logic               r7_ile0;
    logic [QW-1:0]      r7_nmx, r7_nmy;
    logic               r7_sx, r7_sy, r7_zlen, r7_contact;
    logic [HEAT_W-1:0]  r7_ha;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_px      <= r6_sx ? -$signed({1'b0, r6_pmx}) : $signed({1'b0, r6_pmx});
            r7_py      <= r6_sy ? -$signed({1'b0, r6_pmy}) : $signed({1'b0, r6_pmy});
            r7_imag    <= n7_imag;
            r7_ile0    <= n7_ile0;
            r7_nmx     <= r6_nmx;
            r7_nmy     <= r6_nmy;
            r7_sx      <= r6_sx;
            r7_sy      <= r6_sy;
            r7_zlen    <= r6_zlen;
            r7_contact <= r6_contact;
            r7_ha      <= r6_ha;
        end
    end

    // Stage 8: a tenth of |impact|, and |s| = |impact| * (1 + e) / 2
    logic [63:0]      n8_q10p;
    logic [RW-1:0]    n8_onepr;
    logic [31+RW:0]   n8_sprod;

    assign n8_q10p  = 64'(r7_imag) * 64'(RECIP10);
    assign n8_onepr = ONE_Q + RW'(r_restitution);
    assign n8_sprod = (32+RW)'(r7_imag) * (32+RW)'(n8_onepr);

    logic signed [31:0] r8_px, r8_py;
    logic [30:0]        r8_q10;
    logic [SW-1:0]      r8_smag;
    logic               r8_ile0;
    logic [QW-1:0]      r8_nmx, r8_nmy;
    logic               r8_sx, r8_sy, r8_zlen, r8_contact;
    logic [HEAT_W-1:0]  r8_ha;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_px      <= r7_px;
            r8_py      <= r7_py;
            r8_q10     <= 31'(n8_q10p >> RECIP10_SHIFT);
            r8_smag    <= n8_sprod[31+RW:FRAC_BITS+1];
            r8_ile0    <= r7_ile0;
            r8_nmx     <= r7_nmx;
            r8_nmy     <= r7_nmy;
            r8_sx      <= r7_sx;
            r8_sy      <= r7_sy;
            r8_zlen    <= r7_zlen;
            r8_contact <= r7_contact;
            r8_ha      <= r7_ha;
        end
    end

    // Stage 9: heat update, velocity change magnitudes
    logic [31:0]       n9_heat;
    logic [SW+QW-1:0]  n9_mx, n9_my;

    assign n9_heat = 32'(r8_ha) + 32'(r8_q10);
    assign n9_mx   = (SW+QW)'(r8_smag) * (SW+QW)'(r8_nmx);
    assign n9_my   = (SW+QW)'(r8_smag) * (SW+QW)'(r8_nmy);

    logic signed [31:0] r9_px, r9_py;
    logic [HEAT_W-1:0]  r9_heat;
    logic [MW-1:0]      r9_dmx, r9_dmy;
    logic               r9_ile0, r9_sx, r9_sy, r9_zlen, r9_contact;
    logic [HEAT_W-1:0]  r9_ha;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_px      <= r8_px;
            r9_py      <= r8_py;
            r9_heat    <= n9_heat[31] ? HEAT_MAX : n9_heat[30:0];
            r9_dmx     <= n9_mx[SW+QW-1:FRAC_BITS];
            r9_dmy     <= n9_my[SW+QW-1:FRAC_BITS];
            r9_ile0    <= r8_ile0;
            r9_sx      <= r8_sx;
            r9_sy      <= r8_sy;
            r9_zlen    <= r8_zlen;
            r9_contact <= r8_contact;
            r9_ha      <= r8_ha;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 10: saturate the velocity change, zero the push and velocity change and pass
    // the old heat on no contact or coincident centres, and hold the result word for the sink
    // ---------------------------------------------------------------------
    function automatic logic signed [31:0] f_dv_sat(input logic neg, input logic [MW-1:0] m);
        logic signed [31:0] v;
        if (!neg) begin
            v = (m > POS_LIM) ? 32'sh7FFF_FFFF : $signed(32'(m));
        end else begin
            v = (m >= NEG_LIM) ? 32'sh8000_0000 : -$signed(32'(m));
        end
        return v;
    endfunction

    logic               n10_active;
    logic signed [31:0] n10_dvx, n10_dvy;

    assign n10_active = r9_contact & ~r9_zlen;
    assign n10_dvx    = r9_ile0 ? f_dv_sat(r9_sx, r9_dmx) : '0;
    assign n10_dvy    = r9_ile0 ? f_dv_sat(r9_sy, r9_dmy) : '0;

    logic               r10_contact;
    logic signed [31:0] r10_px, r10_py, r10_dvx, r10_dvy;
    logic [HEAT_W-1:0]  r10_heat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_contact <= r9_contact;
            r10_px      <= n10_active ? r9_px : '0;
            r10_py      <= n10_active ? r9_py : '0;
            r10_dvx     <= n10_active ? n10_dvx : '0;
            r10_dvy     <= n10_active ? n10_dvy : '0;
            r10_heat    <= n10_active ? r9_heat : r9_ha;
        end
    end

    assign o_contact     = r10_contact;
    assign o_push_x      = r10_px;
    assign o_push_y      = r10_py;
    assign o_vel_delta_x = r10_dvx;
    assign o_vel_delta_y = r10_dvy;
    assign o_heat_new    = r10_heat;

endmodule

@@ design/cpcr_checker.sv @@
module cpcr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_contact,
    input logic signed [31:0]          o_push_x,
    input logic signed [31:0]          o_push_y,
    input logic signed [31:0]          o_vel_delta_x,
    input logic signed [31:0]          o_vel_delta_y,
    input logic [cpcr_pkg::HEAT_W-1:0] o_heat_new
);
    import cpcr_pkg::*;

    // No contact means no push and no velocity change
    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_contact |-> o_push_x == 0 && o_push_y == 0 &&
                                  o_vel_delta_x == 0 && o_vel_delta_y == 0)
        else $error("nonzero response without contact");

    // Input side stalls only behind a held result word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without an output stall");

    // A held result word keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_push_x) && $stable(o_vel_delta_y) &&
                                $stable(o_heat_new) && $stable(o_contact))
        else $error("result word changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid result after reset");

endmodule

bind circle_pair_collision_response_unit cpcr_checker u_cpcr_checker (.*);

@@ tb/circle_pair_collision_response_unit_test.sv @@
module circle_pair_collision_response_unit_test;
    import cpcr_pkg::*;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;
    localparam int LATENCY = 43 + FB;

    typedef struct packed {
        logic signed [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
        logic [30:0]        ha, hb, sep;
    } t_pair;

    typedef struct packed {
        logic               contact;
        logic signed [31:0] px, py, dvx, dvy;
        logic [30:0]        heat;
    } t_response;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [31:0] i_pos_a_x, i_pos_a_y, i_pos_b_x, i_pos_b_y;
    logic signed [31:0] i_vel_a_x, i_vel_a_y, i_vel_b_x, i_vel_b_y;
    logic [30:0] i_heat_a, i_heat_b, i_separation;
    logic o_contact;
    logic signed [31:0] o_push_x, o_push_y, o_vel_delta_x, o_vel_delta_y;
    logic [30:0] o_heat_new;
    logic i_cfg_we;
    t_reg_idx i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    circle_pair_collision_response_unit #(.FRAC_BITS(FB)) dut (.*);

    // Predictor's own copy of the configuration
    longint radius_q, rest_q;
    t_response pending_responses[$];
    int mismatches = 0;
    bit quiet_src = 0;  // long stretch with no idling on either side
    bit quiet_snk = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > S32MAX) return S32MAX;
        if (v < S32MIN) return S32MIN;
        return v;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Compute the response to one pair of circles
    function automatic t_response collide(t_pair p);
        t_response res;
        longint two_r, sep, ha, hb, dx, dy, nx, ny, w, mag, imp, heat, s, len;
        longint unsigned mx, my;
        res = '0;
        ha = 64'(p.ha);
        hb = 64'(p.hb);
        sep = 64'(p.sep);
        two_r = 2 * radius_q;
        res.heat = p.ha;
        if (sep > two_r) return res;
        res.contact = 1'b1;
        dx = longint'(p.pax) - longint'(p.pbx);
        dy = longint'(p.pay) - longint'(p.pby);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        while (mx >= (64'd1 << 31) || my >= (64'd1 << 31)) begin
            mx >>= 1;
            my >>= 1;
        end
        len = root_floor(mx * mx + my * my);
        if (len == 0) return res;
        nx = longint'((mx << FB) / longint'(len));
        ny = longint'((my << FB) / longint'(len));
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
        w = ((hb + ONE) * ONE) / (ha + hb + 2 * ONE);
        mag = ((two_r - sep) * w) / ONE;
        res.px = 32'(sat32((nx * mag) / ONE));
        res.py = 32'(sat32((ny * mag) / ONE));
        imp = sat32(((longint'(p.vax) - longint'(p.vbx)) * nx
                    + (longint'(p.vay) - longint'(p.vby)) * ny) / ONE);
        heat = ha + (imp < 0 ? -imp : imp) / 10;
        if (heat > S32MAX) heat = S32MAX;
        res.heat = heat[30:0];
        if (imp <= 0) begin
            s = (imp * (ONE + rest_q)) / (2 * ONE);
            res.dvx = 32'(sat32(-((s * nx) / ONE)));
            res.dvy = 32'(sat32(-((s * ny) / ONE)));
        end
        return res;
    endfunction

    // Result sink: random stalls, check every accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            i_ready <= quiet_snk || ($urandom_range(99) >= 18);
            if (o_valid && i_ready) begin
                t_response got, want;
                got = '{o_contact, o_push_x, o_push_y, o_vel_delta_x, o_vel_delta_y,
                        o_heat_new};
                if (pending_responses.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_responses.pop_front();
                    if (got.contact !== want.contact) begin
                        $display("%0t contact: exp %0d got %0d", $time, want.contact,
                                 got.contact);
                        mismatches++;
                    end
                    if (got.px !== want.px) begin
                        $display("%0t push_x: exp %0d got %0d", $time, want.px, got.px);
                        mismatches++;
                    end
                    if (got.py !== want.py) begin
                        $display("%0t push_y: exp %0d got %0d", $time, want.py, got.py);
                        mismatches++;
                    end
                    if (got.dvx !== want.dvx) begin
                        $display("%0t vel_delta_x: exp %0d got %0d", $time, want.dvx,
                                 got.dvx);
                        mismatches++;
                    end
                    if (got.dvy !== want.dvy) begin
                        $display("%0t vel_delta_y: exp %0d got %0d", $time, want.dvy,
                                 got.dvy);
                        mismatches++;
                    end
                    if (got.heat !== want.heat) begin
                        $display("%0t heat_new: exp %0d got %0d", $time, want.heat,
                                 got.heat);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Send one word; hold valid and payload until accepted
    task automatic send_pair(t_pair p);
        while (!quiet_src && $urandom_range(99) < 18) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        {i_pos_a_x, i_pos_a_y, i_pos_b_x, i_pos_b_y, i_vel_a_x, i_vel_a_y,
         i_vel_b_x, i_vel_b_y, i_heat_a, i_heat_b, i_separation} <= p;
        do @(posedge i_clk); while (!o_ready);
        pending_responses.push_back(collide(p));
    endtask

    task automatic drain;
        i_valid <= 0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, longint val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
        if (idx == REG_RADIUS) radius_q = val & 64'h3FFF_FFFF;
        else rest_q = val & 64'h3FFFF;
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 4) - 2;
            3: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pair rnd_pair(bit near);
        t_pair p;
        p.pax = rnd_word(); p.pay = rnd_word();
        p.pbx = rnd_word(); p.pby = rnd_word();
        p.vax = rnd_word(); p.vay = rnd_word();
        p.vbx = rnd_word(); p.vby = rnd_word();
        p.ha = $urandom_range(3) == 0 ? 31'h7FFF_FFFF : 31'($urandom);
        p.hb = $urandom_range(3) == 0 ? 31'd0 : 31'($urandom);
        // mostly overlapping pairs so the response path is exercised
        if (near && radius_q > 0)
            p.sep = 31'($urandom_range(0, 32'(2 * radius_q)));
        else
            p.sep = 31'($urandom);
        return p;
    endfunction

    task automatic test_directed;
        t_pair p;
        p = '0;                          // coincident centres
        send_pair(p);
        p.pax = 32'sh0001_0000; p.vax = -32'sh0002_0000;  // approaching head-on
        p.sep = 31'h0001_0000;
        send_pair(p);
        p.vax = 32'sh0002_0000;          // separating
        send_pair(p);
        p.sep = 31'h7FFF_FFFF;           // no contact
        send_pair(p);
        p.sep = 31'h0002_0000;           // exactly touching
        send_pair(p);
        p.sep = 31'h0002_0001;           // just apart
        send_pair(p);
        p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0};   // extremes, heat saturates
        send_pair(p);
        p.vax = 32'h8000_0000; p.vbx = 32'h7FFF_FFFF;
        p.ha = 31'd0; p.hb = 31'h7FFF_FFFF;
        send_pair(p);
        p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
              31'h0, 31'h0, 31'h1};
        send_pair(p);
        drain();
    endtask

    task automatic test_random(int n, bit quiet);
        quiet_src = quiet;
        quiet_snk = quiet;
        repeat (n) send_pair(rnd_pair($urandom_range(9) < 8));
        quiet_src = 0;
        quiet_snk = 0;
    endtask

    task automatic test_config_sweep;
        // extremes and typical values of both registers
        write_reg(REG_RADIUS, 0);
        write_reg(REG_RESTITUTION, 0);
        test_random(120, 0);
        drain();
        write_reg(REG_RADIUS, 64'h3FFF_FFFF);
        write_reg(REG_RESTITUTION, 64'h3FFFF);
        test_random(200, 0);
        drain();
        write_reg(REG_RADIUS, 64'h0010_0000);
        write_reg(REG_RESTITUTION, 131072);
        test_random(300, 1);
        drain();   // sender holds off until every result has come
        write_reg(REG_RADIUS, $urandom_range(0, 32'h3FFF_FFFF));
        write_reg(REG_RESTITUTION, $urandom_range(0, 32'h3FFFF));
        test_random(300, 0);
        drain();
        write_reg(REG_RADIUS, 65536);
        write_reg(REG_RESTITUTION, 32768);
        test_random(420, 0);
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_RADIUS;
        i_cfg_data = '0;
        {i_pos_a_x, i_pos_a_y, i_pos_b_x, i_pos_b_y, i_vel_a_x, i_vel_a_y,
         i_vel_b_x, i_vel_b_y, i_heat_a, i_heat_b, i_separation} = '0;
        radius_q = 64'(RADIUS_RST);
        rest_q = 64'(REST_RST);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
